FILE: hw/rtl/tsp_pkg.sv
`timescale 1ns / 1ps

package tsp_pkg;

  // Fixed widths of the descriptor fields.
  localparam int unsigned TimeW  = 64;
  localparam int unsigned IndexW = 4;

  // Scale factors and saturation value.
  localparam logic [TimeW-1:0] ALL_ONES  = '1;
  localparam logic [TimeW-1:0] NS_PER_S  = 64'd1000000000;
  localparam logic [TimeW-1:0] NS_PER_US = 64'd1000;

  // Largest operands whose scaled product still fits in 64 bits.
  localparam logic [TimeW-1:0] XFER_LIMIT = ALL_ONES / NS_PER_S;
  localparam logic [TimeW-1:0] LAT_LIMIT  = ALL_ONES / NS_PER_US;

  // Bit positions of the highest set bit of each scale factor.
  localparam logic [5:0] NS_PER_S_TOP  = 6'd29;
  localparam logic [5:0] NS_PER_US_TOP = 6'd9;

  // Reason codes carried in each result word.
  localparam logic [1:0] REASON_INELIGIBLE = 2'd0;
  localparam logic [1:0] REASON_UNKNOWN    = 2'd1;
  localparam logic [1:0] REASON_NORMAL     = 2'd2;

  // Estimator result toward the top level.
  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] est_time;
  } est_result_t;

  // Ranking status toward the top level, indices already cut to the port width.
  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] chosen_index;
    logic              has_fallback;
    logic [IndexW-1:0] fallback_index;
  } rank_status_t;

endpackage

FILE: hw/rtl/tsp_est.sv
`timescale 1ns / 1ps

// Completion-time estimator built around one 65-bit adder/subtractor.
// The adder serves a shift-add multiply by 1e9, a restoring divide by the
// throughput, a shift-add multiply by 1000 and the final saturating sum.
module tsp_est (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [63:0]               rate_i,
  input  logic [63:0]               lat_i,
  input  logic [63:0]               bytes_i,
  output tsp_pkg::est_result_t      result_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_DIV,
    ST_MUL_L,
    ST_SUM
  } state_e;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] rate_q, rate_d;
  logic [63:0] lat_q, lat_d;
  logic [63:0] bytes_q, bytes_d;
  logic        lsat_q, lsat_d;
  logic        done_q, done_d;
  logic [63:0] res_q, res_d;

  // Shared adder operands.
  logic [64:0] op_a;
  logic [64:0] op_b;
  logic        sub;
  logic [65:0] sum;

  // Operand selection for the shared adder.
  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    case (state_q)
      ST_MUL_X: begin
        op_a = {1'b0, acc_q[62:0], 1'b0};
        op_b = tsp_pkg::NS_PER_S[cnt_q] ? {1'b0, bytes_q} : '0;
      end
      ST_DIV: begin
        op_a = {rem_q, acc_q[63]};
        op_b = {1'b0, rate_q};
        sub  = 1'b1;
      end
      ST_MUL_L: begin
        op_a = {1'b0, rem_q[62:0], 1'b0};
        op_b = tsp_pkg::NS_PER_US[cnt_q] ? {1'b0, lat_q} : '0;
      end
      ST_SUM: begin
        op_a = {1'b0, acc_q};
        op_b = {1'b0, rem_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {65'd0, sub};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    rate_d  = rate_q;
    lat_d   = lat_q;
    bytes_d = bytes_q;
    lsat_d  = lsat_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rate_d  = rate_i;
          lat_d   = lat_i;
          bytes_d = bytes_i;
          lsat_d  = (lat_i > tsp_pkg::LAT_LIMIT);
          rem_d   = '0;
          if (bytes_i > tsp_pkg::XFER_LIMIT) begin
            // The transfer term saturates, so the divide is skipped.
            acc_d = tsp_pkg::ALL_ONES;
            if (lat_i > tsp_pkg::LAT_LIMIT) begin
              state_d = ST_SUM;
            end else begin
              cnt_d   = tsp_pkg::NS_PER_US_TOP;
              state_d = ST_MUL_L;
            end
          end else begin
            acc_d   = '0;
            cnt_d   = tsp_pkg::NS_PER_S_TOP;
            state_d = ST_MUL_X;
          end
        end
      end
      ST_MUL_X: begin
        acc_d = sum[63:0];
        if (cnt_q == '0) begin
          cnt_d   = 6'd63;
          rem_d   = '0;
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; the remainder stays below the divisor.
        acc_d = {acc_q[62:0], sum[65]};
        rem_d = sum[65] ? sum[63:0] : op_a[63:0];
        if (cnt_q == '0) begin
          rem_d = '0;
          if (lsat_q) begin
            state_d = ST_SUM;
          end else begin
            cnt_d   = tsp_pkg::NS_PER_US_TOP;
            state_d = ST_MUL_L;
          end
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      ST_MUL_L: begin
        rem_d = sum[63:0];
        if (cnt_q == '0) begin
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      ST_SUM: begin
        res_d   = (lsat_q || sum[64]) ? tsp_pkg::ALL_ONES : sum[63:0];
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    rate_q  <= rate_d;
    lat_q   <= lat_d;
    bytes_q <= bytes_d;
    lsat_q  <= lsat_d;
    res_q   <= res_d;
  end

  assign result_o.done     = done_q;
  assign result_o.est_time = res_q;

endmodule

FILE: hw/rtl/tsp_rank.sv
`timescale 1ns / 1ps

// Keeps the best and second-best eligible sources, ordered by estimate,
// then key, then position.
module tsp_rank #(
  parameter int unsigned PosW = 4,
  parameter int unsigned KeyW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  upd_i,
  input  logic                  clr_i,
  input  logic [63:0]           time_i,
  input  logic [KeyW-1:0]       key_i,
  input  logic [PosW-1:0]       pos_i,
  output tsp_pkg::rank_status_t status_o
);

  logic                  best_valid_q, best_valid_d;
  logic                  second_valid_q, second_valid_d;
  logic [63:0]           best_time_q, best_time_d;
  logic [KeyW-1:0]       best_key_q, best_key_d;
  logic [PosW-1:0]       best_pos_q, best_pos_d;
  logic [63:0]           second_time_q, second_time_d;
  logic [KeyW-1:0]       second_key_q, second_key_d;
  logic [PosW-1:0]       second_pos_q, second_pos_d;
  logic                  before_best;
  logic                  before_second;
  logic [7:0]            best_pos_ext;
  logic [7:0]            second_pos_ext;

  // Lexicographic compares of the new entry against both kept entries.
  assign before_best   = {time_i, key_i, pos_i} < {best_time_q, best_key_q, best_pos_q};
  assign before_second = {time_i, key_i, pos_i} < {second_time_q, second_key_q, second_pos_q};

  // Insertion into the two-entry ranking.
  always_comb begin
    best_valid_d   = best_valid_q;
    second_valid_d = second_valid_q;
    best_time_d    = best_time_q;
    best_key_d     = best_key_q;
    best_pos_d     = best_pos_q;
    second_time_d  = second_time_q;
    second_key_d   = second_key_q;
    second_pos_d   = second_pos_q;
    if (clr_i) begin
      best_valid_d   = 1'b0;
      second_valid_d = 1'b0;
    end else if (upd_i) begin
      if (!best_valid_q) begin
        best_valid_d = 1'b1;
        best_time_d  = time_i;
        best_key_d   = key_i;
        best_pos_d   = pos_i;
      end else if (before_best) begin
        second_valid_d = 1'b1;
        second_time_d  = best_time_q;
        second_key_d   = best_key_q;
        second_pos_d   = best_pos_q;
        best_time_d    = time_i;
        best_key_d     = key_i;
        best_pos_d     = pos_i;
      end else if (!second_valid_q || before_second) begin
        second_valid_d = 1'b1;
        second_time_d  = time_i;
        second_key_d   = key_i;
        second_pos_d   = pos_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q   <= 1'b0;
      second_valid_q <= 1'b0;
    end else begin
      best_valid_q   <= best_valid_d;
      second_valid_q <= second_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_time_q   <= best_time_d;
    best_key_q    <= best_key_d;
    best_pos_q    <= best_pos_d;
    second_time_q <= second_time_d;
    second_key_q  <= second_key_d;
    second_pos_q  <= second_pos_d;
  end

  // Positions are cut to the width of the index ports.
  assign best_pos_ext   = 8'(best_pos_q);
  assign second_pos_ext = 8'(second_pos_q);

  assign status_o.found          = best_valid_q;
  assign status_o.chosen_index   = best_valid_q ? best_pos_ext[3:0] : '0;
  assign status_o.has_fallback   = second_valid_q;
  assign status_o.fallback_index = second_valid_q ? second_pos_ext[3:0] : '0;

endmodule

FILE: hw/rtl/transfer_source_picker_core.sv
`timescale 1ns / 1ps

// Transfer source picker.
// The input channel (in_valid_i / in_stall_o) carries one source descriptor
// per word; the output channel (out_valid_o / out_stall_i) returns one
// result word per descriptor, in order. A word moves when valid is high and
// stall is low. The word marked last_source_i also reports the best and the
// second-best eligible source of the list, and then the ranking is cleared.
// For an eligible source with known throughput the shared 65-bit adder
// runs the multiply by 1e9, the divide by the throughput, the multiply by
// 1000 and the final sum in turn; the handoff, the ranking and the output
// load follow. A transfer size too large for the multiply skips multiply
// and divide (and the multiply by 1000 too when the latency term
// saturates); unknown throughput skips the estimate, and an ineligible
// source skips the estimate and the ranking.
// One descriptor is in work at a time.
// The output register holds a finished word while out_stall_i is high; the
// next descriptor is taken meanwhile and waits for the slot when it is done.
// Reset clears the position counter, the ranking and the output valid.
module transfer_source_picker_core #(
  parameter int unsigned MAX_SOURCES = 16,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        available_i,
  input  logic        exact_reads_i,
  input  logic        has_handle_i,
  input  logic [63:0] throughput_i,
  input  logic [63:0] latency_us_i,
  input  logic [31:0] source_key_i,
  input  logic [63:0] xfer_bytes_i,
  input  logic        last_source_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  item_index_o,
  output logic        eligible_o,
  output logic [1:0]  reason_code_o,
  output logic [63:0] estimated_time_o,
  output logic        last_result_o,
  output logic        found_o,
  output logic [3:0]  chosen_index_o,
  output logic        has_fallback_o,
  output logic [3:0]  fallback_index_o
);

  localparam int unsigned PosW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned KeyW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_SOURCES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EST,
    ST_RANK,
    ST_OUT
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] count_q, count_d;
  logic            ok_q, ok_d;
  logic            last_q, last_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [63:0]     time_q, time_d;
  logic [1:0]      reason_q, reason_d;
  logic            out_valid_q, out_valid_d;
  logic [3:0]      out_index_q;
  logic            out_ok_q;
  logic [1:0]      out_reason_q;
  logic [63:0]     out_time_q;
  logic            out_last_q;
  logic            out_found_q;
  logic [3:0]      out_chosen_q;
  logic            out_has_fb_q;
  logic [3:0]      out_fb_q;

  logic                   accept;
  logic                   ok_in;
  logic                   est_start;
  logic                   rank_upd;
  logic                   load;
  logic [7:0]             pos_ext;
  tsp_pkg::est_result_t   est_res;
  tsp_pkg::rank_status_t  rank_st;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign ok_in      = available_i && exact_reads_i && has_handle_i;
  assign est_start  = accept && ok_in && (throughput_i != '0);
  assign rank_upd   = (state_q == ST_RANK);
  assign load       = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  tsp_est u_est (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (est_start),
    .rate_i   (throughput_i),
    .lat_i    (latency_us_i),
    .bytes_i  (xfer_bytes_i),
    .result_o (est_res)
  );

  tsp_rank #(
    .PosW (PosW),
    .KeyW (KeyW)
  ) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (rank_upd),
    .clr_i    (load && last_q),
    .time_i   (time_q),
    .key_i    (key_q),
    .pos_i    (pos_q),
    .status_o (rank_st)
  );

  // Item sequencing.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ok_d     = ok_q;
    last_d   = last_q;
    pos_d    = pos_q;
    key_d    = key_q;
    time_d   = time_q;
    reason_d = reason_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d     = ok_in;
          last_d   = last_source_i;
          pos_d    = count_q;
          key_d    = source_key_i[KeyW-1:0];
          time_d   = tsp_pkg::ALL_ONES;
          reason_d = tsp_pkg::REASON_INELIGIBLE;
          if (last_source_i) begin
            count_d = '0;
          end else if (count_q != PosMax) begin
            count_d = count_q + PosW'(1);
          end
          if (!ok_in) begin
            state_d = ST_OUT;
          end else if (throughput_i == '0) begin
            reason_d = tsp_pkg::REASON_UNKNOWN;
            state_d  = ST_RANK;
          end else begin
            reason_d = tsp_pkg::REASON_NORMAL;
            state_d  = ST_EST;
          end
        end
      end
      ST_EST: begin
        if (est_res.done) begin
          time_d  = est_res.est_time;
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output word stays until the receiver takes it.
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    last_q   <= last_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    time_q   <= time_d;
    reason_q <= reason_d;
  end

  // Output register fields.
  assign pos_ext = 8'(pos_q);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_index_q  <= pos_ext[3:0];
      out_ok_q     <= ok_q;
      out_reason_q <= reason_q;
      out_time_q   <= time_q;
      out_last_q   <= last_q;
      out_found_q  <= last_q && rank_st.found;
      out_chosen_q <= last_q ? rank_st.chosen_index : '0;
      out_has_fb_q <= last_q && rank_st.has_fallback;
      out_fb_q     <= last_q ? rank_st.fallback_index : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_index_o     = out_index_q;
  assign eligible_o       = out_ok_q;
  assign reason_code_o    = out_reason_q;
  assign estimated_time_o = out_time_q;
  assign last_result_o    = out_last_q;
  assign found_o          = out_found_q;
  assign chosen_index_o   = out_chosen_q;
  assign has_fallback_o   = out_has_fb_q;
  assign fallback_index_o = out_fb_q;

endmodule

FILE: tb/transfer_source_picker_core_test.sv
`timescale 1ns / 1ps

module transfer_source_picker_core_test;

  localparam int unsigned MAX_SOURCES = 16;
  localparam int unsigned KEY_BITS    = 32;

  localparam logic [63:0] TIME_SAT  = tsp_pkg::ALL_ONES;
  localparam logic [63:0] BYTES_MAX = tsp_pkg::ALL_ONES / tsp_pkg::NS_PER_S;
  localparam logic [63:0] LAT_MAX   = tsp_pkg::ALL_ONES / tsp_pkg::NS_PER_US;

  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned PHASE_WORDS   = 150;

  typedef struct packed {
    logic        available;
    logic        exact_reads;
    logic        has_handle;
    logic [63:0] throughput;
    logic [63:0] latency_us;
    logic [31:0] source_key;
    logic [63:0] xfer_bytes;
    logic        last_source;
  } descriptor_t;

  typedef struct packed {
    logic [tsp_pkg::IndexW-1:0] item_index;
    logic                       eligible;
    logic [1:0]                 reason_code;
    logic [tsp_pkg::TimeW-1:0]  estimated_time;
    logic                       last_result;
    logic                       found;
    logic [tsp_pkg::IndexW-1:0] chosen_index;
    logic                       has_fallback;
    logic [tsp_pkg::IndexW-1:0] fallback_index;
  } outcome_t;

  typedef struct packed {
    descriptor_t word;
    logic        typed;
    outcome_t    result;
  } plan_row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        available_i      = 1'b0;
  logic        exact_reads_i    = 1'b0;
  logic        has_handle_i     = 1'b0;
  logic [63:0] throughput_i     = '0;
  logic [63:0] latency_us_i     = '0;
  logic [31:0] source_key_i     = '0;
  logic [63:0] xfer_bytes_i     = '0;
  logic        last_source_i    = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [3:0]  item_index_o;
  logic        eligible_o;
  logic [1:0]  reason_code_o;
  logic [63:0] estimated_time_o;
  logic        last_result_o;
  logic        found_o;
  logic [3:0]  chosen_index_o;
  logic        has_fallback_o;
  logic [3:0]  fallback_index_o;

  transfer_source_picker_core #(
    .MAX_SOURCES(MAX_SOURCES),
    .KEY_BITS   (KEY_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .available_i     (available_i),
    .exact_reads_i   (exact_reads_i),
    .has_handle_i    (has_handle_i),
    .throughput_i    (throughput_i),
    .latency_us_i    (latency_us_i),
    .source_key_i    (source_key_i),
    .xfer_bytes_i    (xfer_bytes_i),
    .last_source_i   (last_source_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .item_index_o    (item_index_o),
    .eligible_o      (eligible_o),
    .reason_code_o   (reason_code_o),
    .estimated_time_o(estimated_time_o),
    .last_result_o   (last_result_o),
    .found_o         (found_o),
    .chosen_index_o  (chosen_index_o),
    .has_fallback_o  (has_fallback_o),
    .fallback_index_o(fallback_index_o)
  );

  // Ranking state of the list in progress, mirrored from the block.
  int unsigned list_pos;
  logic        lead_valid;
  logic [63:0] lead_time;
  logic [31:0] lead_key;
  int unsigned lead_pos;
  logic        runner_valid;
  logic [63:0] runner_time;
  logic [31:0] runner_key;
  int unsigned runner_pos;

  outcome_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_output = 1'b0;

  plan_row_t   directed_plan[14];

  // Free-running clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #20_000_000;
    $display("FAIL transfer_source_picker_core");
    $finish;
  end

  function automatic void clear_ranking();
    list_pos     = 0;
    lead_valid   = 1'b0;
    lead_time    = '0;
    lead_key     = '0;
    lead_pos     = 0;
    runner_valid = 1'b0;
    runner_time  = '0;
    runner_key   = '0;
    runner_pos   = 0;
  endfunction

  // Completion estimate in ns; each term and the sum saturate.
  function automatic logic [63:0] completion_ns(input logic [63:0] rate,
                                                input logic [63:0] lat_us,
                                                input logic [63:0] bytes);
    logic [63:0] xfer;
    logic [63:0] lat_ns;
    if (rate == '0) begin
      return TIME_SAT;
    end
    xfer   = (bytes > BYTES_MAX) ? TIME_SAT : (bytes * tsp_pkg::NS_PER_S) / rate;
    lat_ns = (lat_us > LAT_MAX) ? TIME_SAT : lat_us * tsp_pkg::NS_PER_US;
    if (xfer > TIME_SAT - lat_ns) begin
      return TIME_SAT;
    end
    return xfer + lat_ns;
  endfunction

  // Ordering by estimate, then key, then position.
  function automatic bit faster_than(input logic [63:0] t1, input logic [31:0] k1,
                                     input int unsigned p1, input logic [63:0] t2,
                                     input logic [31:0] k2, input int unsigned p2);
    if (t1 != t2) begin
      return t1 < t2;
    end
    if (k1 != k2) begin
      return k1 < k2;
    end
    return p1 < p2;
  endfunction

  // Predicts the result word for one accepted descriptor and updates the ranking.
  function automatic outcome_t pick_step(input descriptor_t word);
    outcome_t    res;
    logic        ok;
    int unsigned pos;
    logic [63:0] est;
    ok  = word.available && word.exact_reads && word.has_handle;
    pos = list_pos;
    est = TIME_SAT;
    res = '0;
    if (list_pos < MAX_SOURCES - 1) begin
      list_pos++;
    end
    res.reason_code = tsp_pkg::REASON_INELIGIBLE;
    if (ok) begin
      res.reason_code = (word.throughput == '0) ? tsp_pkg::REASON_UNKNOWN
                                                : tsp_pkg::REASON_NORMAL;
      est = completion_ns(word.throughput, word.latency_us, word.xfer_bytes);
      if (!lead_valid) begin
        lead_valid = 1'b1;
        lead_time  = est;
        lead_key   = word.source_key;
        lead_pos   = pos;
      end else if (faster_than(est, word.source_key, pos, lead_time, lead_key, lead_pos)) begin
        runner_valid = 1'b1;
        runner_time  = lead_time;
        runner_key   = lead_key;
        runner_pos   = lead_pos;
        lead_time    = est;
        lead_key     = word.source_key;
        lead_pos     = pos;
      end else if (!runner_valid ||
                   faster_than(est, word.source_key, pos, runner_time, runner_key,
                               runner_pos)) begin
        runner_valid = 1'b1;
        runner_time  = est;
        runner_key   = word.source_key;
        runner_pos   = pos;
      end
    end
    res.item_index     = pos[3:0];
    res.eligible       = ok;
    res.estimated_time = est;
    res.last_result    = word.last_source;
    if (word.last_source) begin
      if (lead_valid) begin
        res.found        = 1'b1;
        res.chosen_index = lead_pos[3:0];
      end
      if (runner_valid) begin
        res.has_fallback   = 1'b1;
        res.fallback_index = runner_pos[3:0];
      end
      clear_ranking();
    end
    return res;
  endfunction

  function automatic descriptor_t make_word(input logic avail, input logic rng,
                                            input logic hnd, input logic [63:0] rate,
                                            input logic [63:0] lat, input logic [31:0] key,
                                            input logic [63:0] bytes, input logic last);
    descriptor_t w;
    w = '{avail, rng, hnd, rate, lat, key, bytes, last};
    return w;
  endfunction

  // Result of a one-descriptor list, where the ranking fields follow directly.
  function automatic outcome_t single_result(input logic ok, input logic [1:0] reason,
                                             input logic [63:0] est);
    outcome_t r;
    r = '0;
    r.eligible       = ok;
    r.reason_code    = reason;
    r.estimated_time = est;
    r.last_result    = 1'b1;
    r.found          = ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: result %0d: %s is %0h, expected %0h", $realtime, result_count, what,
             got, want);
    mismatch_count++;
  endtask

  // Presents one descriptor word, waits for it to be taken and records its result.
  task automatic offer_word(input descriptor_t word, input logic typed,
                            input outcome_t typed_result);
    outcome_t predicted;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    available_i     <= word.available;
    exact_reads_i   <= word.exact_reads;
    has_handle_i    <= word.has_handle;
    throughput_i    <= word.throughput;
    latency_us_i    <= word.latency_us;
    source_key_i    <= word.source_key;
    xfer_bytes_i    <= word.xfer_bytes;
    last_source_i   <= word.last_source;
    do @(posedge clk_i); while (in_stall_o);
    predicted = pick_step(word);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
  endtask

  // Drops valid and waits until every result word is back and the block is quiet.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_rate();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TIME_SAT;
      2:       return {$urandom, $urandom};
      3:       return 64'($urandom_range(1, 1000));
      default: return {30'd0, 2'($urandom_range(0, 2)), 32'($urandom)} + 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] random_bytes();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TIME_SAT;
      2:       return {$urandom, $urandom};
      3:       return BYTES_MAX + 64'($urandom_range(0, 1));
      default: return {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] random_latency();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TIME_SAT;
      2:       return {$urandom, $urandom};
      3:       return LAT_MAX + 64'($urandom_range(0, 1));
      default: return 64'($urandom_range(0, 100000));
    endcase
  endfunction

  // Sends one list of random descriptors; ties and long lists are frequent.
  task automatic send_random_list(inout int unsigned sent);
    int unsigned length;
    int unsigned tie_pct;
    logic [63:0] list_bytes;
    descriptor_t word;
    descriptor_t prev;
    length     = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
    tie_pct    = ($urandom_range(0, 3) == 0) ? 90 : 15;
    list_bytes = random_bytes();
    prev       = '0;
    for (int unsigned i = 0; i < length; i++) begin
      word.available     = ($urandom_range(0, 9) != 0);
      word.exact_reads   = ($urandom_range(0, 9) != 0);
      word.has_handle    = ($urandom_range(0, 9) != 0);
      word.throughput    = random_rate();
      word.latency_us    = random_latency();
      word.source_key    = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
      word.xfer_bytes    = ($urandom_range(0, 19) == 0) ? random_bytes() : list_bytes;
      if (i > 0 && $urandom_range(0, 99) < tie_pct) begin
        word.throughput = prev.throughput;
        word.latency_us = prev.latency_us;
        word.xfer_bytes = prev.xfer_bytes;
        if ($urandom_range(0, 1) == 0) begin
          word.source_key = prev.source_key;
        end
      end
      word.last_source = (i == length - 1);
      offer_word(word, 1'b0, '0);
      prev = word;
      sent++;
    end
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(negedge clk_i) begin
    out_stall_i <= hold_output || ($urandom_range(0, 99) < stall_pct);
  end

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{item_index_o, eligible_o, reason_code_o, estimated_time_o, last_result_o,
              found_o, chosen_index_o, has_fallback_o, fallback_index_o};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(got.item_index), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.item_index != want.item_index)
          report_mismatch("item_index", 64'(got.item_index), 64'(want.item_index));
        if (got.eligible != want.eligible)
          report_mismatch("eligible", 64'(got.eligible), 64'(want.eligible));
        if (got.reason_code != want.reason_code)
          report_mismatch("reason_code", 64'(got.reason_code), 64'(want.reason_code));
        if (got.estimated_time != want.estimated_time)
          report_mismatch("estimated_time", got.estimated_time, want.estimated_time);
        if (got.last_result != want.last_result)
          report_mismatch("last_result", 64'(got.last_result), 64'(want.last_result));
        if (got.found != want.found)
          report_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.chosen_index != want.chosen_index)
          report_mismatch("chosen_index", 64'(got.chosen_index), 64'(want.chosen_index));
        if (got.has_fallback != want.has_fallback)
          report_mismatch("has_fallback", 64'(got.has_fallback), 64'(want.has_fallback));
        if (got.fallback_index != want.fallback_index)
          report_mismatch("fallback_index", 64'(got.fallback_index),
                          64'(want.fallback_index));
      end
      result_count++;
    end
  end

  // Main sequence: reset, directed table, then random lists in four idling phases.
  initial begin
    int unsigned sent;
    clear_ranking();

    // Single-descriptor lists whose results follow directly from the fields.
    directed_plan[0] = '{make_word(1'b0, 1'b1, 1'b1, 64'd1000000000, 64'd0, 32'd5,
                                   64'd1000, 1'b1), 1'b1,
                         single_result(1'b0, tsp_pkg::REASON_INELIGIBLE, TIME_SAT)};
    directed_plan[1] = '{make_word(1'b1, 1'b0, 1'b1, 64'd1000000000, 64'd0, 32'd5,
                                   64'd1000, 1'b1), 1'b1,
                         single_result(1'b0, tsp_pkg::REASON_INELIGIBLE, TIME_SAT)};
    directed_plan[2] = '{make_word(1'b1, 1'b1, 1'b0, 64'd1000000000, 64'd0, 32'd5,
                                   64'd1000, 1'b1), 1'b1,
                         single_result(1'b0, tsp_pkg::REASON_INELIGIBLE, TIME_SAT)};
    directed_plan[3] = '{make_word(1'b1, 1'b1, 1'b1, 64'd0, 64'd0, 32'd0,
                                   64'd1000, 1'b1), 1'b1,
                         single_result(1'b1, tsp_pkg::REASON_UNKNOWN, TIME_SAT)};
    directed_plan[4] = '{make_word(1'b1, 1'b1, 1'b1, 64'd1, 64'd0, 32'd9,
                                   TIME_SAT, 1'b1), 1'b1,
                         single_result(1'b1, tsp_pkg::REASON_NORMAL, TIME_SAT)};
    directed_plan[5] = '{make_word(1'b1, 1'b1, 1'b1, 64'd1, TIME_SAT, 32'd9,
                                   64'd0, 1'b1), 1'b1,
                         single_result(1'b1, tsp_pkg::REASON_NORMAL, TIME_SAT)};
    directed_plan[6] = '{make_word(1'b1, 1'b1, 1'b1, TIME_SAT, 64'd0, 32'hFFFF_FFFF,
                                   64'd0, 1'b1), 1'b1,
                         single_result(1'b1, tsp_pkg::REASON_NORMAL, 64'd0)};
    directed_plan[7] = '{make_word(1'b1, 1'b1, 1'b1, 64'd1000000000, 64'd1, 32'd2,
                                   64'd1, 1'b1), 1'b1,
                         single_result(1'b1, tsp_pkg::REASON_NORMAL, 64'd1001)};
    // A list with ties on estimate and key, an ineligible entry and a late winner.
    directed_plan[8]  = '{make_word(1'b1, 1'b1, 1'b1, 64'd1000000000, 64'd5, 32'd7,
                                    64'd1000, 1'b0), 1'b0, '0};
    directed_plan[9]  = '{make_word(1'b1, 1'b1, 1'b1, 64'd1000000000, 64'd5, 32'd3,
                                    64'd1000, 1'b0), 1'b0, '0};
    directed_plan[10] = '{make_word(1'b1, 1'b1, 1'b1, 64'd1000000000, 64'd5, 32'd3,
                                    64'd1000, 1'b0), 1'b0, '0};
    directed_plan[11] = '{make_word(1'b0, 1'b0, 1'b0, TIME_SAT, TIME_SAT, 32'hFFFF_FFFF,
                                    64'd1000, 1'b0), 1'b0, '0};
    directed_plan[12] = '{make_word(1'b1, 1'b1, 1'b1, 64'd2000000000, 64'd0, 32'd1,
                                    64'd1000, 1'b0), 1'b0, '0};
    directed_plan[13] = '{make_word(1'b1, 1'b1, 1'b1, 64'd0, 64'd0, 32'd4,
                                    64'd1000, 1'b1), 1'b0, '0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      offer_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].result);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 77;
        end
        default: begin
          send_idle_pct = 38;
          stall_pct     = 38;
        end
      endcase
      // Long receiver hold-off so the output slot fills and the input stalls.
      if (phase == 0) begin
        fork
          begin
            hold_output = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_output = 1'b0;
          end
        join_none
      end
      sent = 0;
      while (sent < PHASE_WORDS) begin
        send_random_list(sent);
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("PASS transfer_source_picker_core");
    end else begin
      $display("FAIL transfer_source_picker_core");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_est.sv
hw/rtl/tsp_rank.sv
hw/rtl/transfer_source_picker_core.sv
tb/transfer_source_picker_core_test.sv
